[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sector transfer link checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/stle_pkg.sv]
// ----------------------------------------------------------------------------
// stle_pkg
// Types, codes and constants of the sector transfer link engine.
// ----------------------------------------------------------------------------
package stle_pkg;

    localparam logic [11:0] MAX_SECTORS  = 12'd2048;
    localparam logic [8:0]  SECTOR_BYTES = 9'd256;
    localparam logic [10:0] UPPER_BASE   = 11'd2040;
    localparam logic [12:0] UPPER_COUNT  = 13'd8;
    localparam int          MAX_RESULTS  = 5;

    localparam logic [7:0] BYTE_START   = 8'h01;
    localparam logic [7:0] BYTE_WRITE   = 8'h00;
    localparam logic [7:0] BYTE_READ    = 8'h01;
    localparam logic [7:0] REPLY_OK     = 8'hFF;
    localparam logic [7:0] REPLY_RDATA  = 8'hFE;

    localparam logic [2:0] CMD_START_WRITE = 3'd0;
    localparam logic [2:0] CMD_DATA        = 3'd1;
    localparam logic [2:0] CMD_WRITE_REPLY = 3'd2;
    localparam logic [2:0] CMD_START_READ  = 3'd3;
    localparam logic [2:0] CMD_READ_REPLY  = 3'd4;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_RETRY    = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_SKIPPED  = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;
    localparam logic [2:0] ST_NO_IMAGE = 3'd6;

    localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_BANK_TYPE    = 3'd1;
    localparam logic [2:0] CFG_IMAGE_SECTOR = 3'd2;
    localparam logic [2:0] CFG_SPLIT        = 3'd3;
    localparam logic [2:0] CFG_INCREMENTAL  = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WDATA  = 5'b00010,
        PH_WREPLY = 5'b00100,
        PH_RRESP  = 5'b01000,
        PH_RDATA  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [7:0] rx_byte;
        logic       sector_changed;
    } req_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  status;
        logic [10:0] sector_number;
        logic        all_done;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [2:0]                       count;
        rsp_item_t [MAX_RESULTS-1:0]      items;
    } rsp_bundle_t;

    function automatic rsp_item_t make_rsp(input logic tx_valid, input logic [7:0] tx_byte,
                                           input logic [2:0] status,
                                           input logic [10:0] sector);
        rsp_item_t r;
        r.tx_valid      = tx_valid;
        r.tx_byte       = tx_valid ? tx_byte : 8'h00;
        r.status        = status;
        r.sector_number = sector;
        r.all_done      = 1'b0;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

[src/sector_transfer_link_engine_unit.sv]
// ----------------------------------------------------------------------------
// sector_transfer_link_engine_unit
// Byte link engine that writes 256-byte sectors and reads them back for checking.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register until the result register can
//   take its results; the first of them is then presented from the result register.
// Throughput: one item per cycle while rsp_stall is low and each item yields at
//   most one result; an item yielding n results holds the result register until all
//   are taken (start commands opening a transfer give five, last write data byte two).
// Reset: rst_n clears all sector state and all configuration registers; the phase goes to idle.
module sector_transfer_link_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  stle_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output stle_pkg::rsp_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data
);
    import stle_pkg::*;

    rsp_bundle_t bundle;
    logic        load_ok;
    logic        fire;

    stle_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_ok   (load_ok),
        .fire      (fire),
        .bundle    (bundle)
    );

    stle_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .bundle    (bundle),
        .load_ok   (load_ok),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[src/stle_engine.sv]
// ----------------------------------------------------------------------------
// stle_engine
// Input register, configuration registers and the per-item transfer logic.
// ----------------------------------------------------------------------------
module stle_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  stle_pkg::req_item_t req,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                load_ok,
    output logic                fire,
    output stle_pkg::rsp_bundle_t bundle
);
    import stle_pkg::*;

    logic        req_full_reg, req_full_next;
    req_item_t   req_reg;

    logic [7:0]  retry_limit_reg;
    logic [7:0]  bank_type_reg;
    logic [11:0] image_reg;
    logic        split_reg;
    logic        incr_reg;

    logic [10:0] sector_reg, sector_next;
    logic [11:0] handled_reg, handled_next;
    logic [7:0]  retries_reg, retries_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  first_reg, first_next;
    logic        mismatch_reg, mismatch_next;

    logic [11:0] eff_image;
    logic [12:0] target;
    logic        done_now, done_next;
    logic [10:0] adv_sector, inc_sector;
    logic [2:0]  fail_status;
    logic [7:0]  fail_retries;
    logic [7:0]  hi, lo;
    logic        do_advance, do_fail;

    assign cfg_ready = 1'b1;
    assign fire      = req_full_reg && load_ok;
    assign req_stall = req_full_reg && !fire;

    always_comb
    begin
        req_full_next = req_full_reg;
        if (req_valid && !req_stall)
        begin
            req_full_next = 1'b1;
        end
        else if (fire)
        begin
            req_full_next = 1'b0;
        end
    end

    assign eff_image  = (image_reg > MAX_SECTORS) ? MAX_SECTORS : image_reg;
    assign target     = {1'b0, eff_image} + (split_reg ? UPPER_COUNT : 13'd0);
    assign done_now   = (eff_image != 12'd0) && ({1'b0, handled_reg} >= target);
    assign inc_sector = sector_reg + 11'd1;
    assign adv_sector = (split_reg && ({1'b0, inc_sector} == eff_image)) ? UPPER_BASE
                                                                          : inc_sector;
    assign fail_status  = (retries_reg < retry_limit_reg) ? ST_RETRY : ST_FAILED;
    assign fail_retries = (retries_reg < retry_limit_reg) ? retries_reg + 8'd1 : 8'd0;
    assign hi = {5'd0, sector_reg[10:8]};
    assign lo = sector_reg[7:0];

    always_comb
    begin
        sector_next   = sector_reg;
        handled_next  = handled_reg;
        retries_next  = retries_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        xor_next      = xor_reg;
        first_next    = first_reg;
        mismatch_next = mismatch_reg;
        do_advance    = 1'b0;
        do_fail       = 1'b0;
        bundle        = '0;

        if (fire)
        begin
            case (req_reg.cmd)
                CMD_START_WRITE, CMD_START_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        bundle.count = 3'd1;
                        if (eff_image == 12'd0)
                        begin
                            bundle.items[0] = make_rsp(1'b0, 8'h00, ST_NO_IMAGE, sector_reg);
                        end
                        else if (done_now)
                        begin
                            bundle.items[0] = make_rsp(1'b0, 8'h00, ST_DONE, sector_reg);
                        end
                        else if (req_reg.cmd == CMD_START_WRITE && incr_reg
                                 && !req_reg.sector_changed)
                        begin
                            do_advance      = 1'b1;
                            bundle.items[0] = make_rsp(1'b0, 8'h00, ST_SKIPPED, sector_reg);
                        end
                        else if (req_reg.cmd == CMD_START_WRITE)
                        begin
                            bundle.count    = 3'd5;
                            bundle.items[0] = make_rsp(1'b1, BYTE_START, ST_BUSY, sector_reg);
                            bundle.items[1] = make_rsp(1'b1, BYTE_WRITE, ST_BUSY, sector_reg);
                            bundle.items[2] = make_rsp(1'b1, hi, ST_BUSY, sector_reg);
                            bundle.items[3] = make_rsp(1'b1, lo, ST_BUSY, sector_reg);
                            bundle.items[4] = make_rsp(1'b1, bank_type_reg, ST_BUSY,
                                                       sector_reg);
                            xor_next   = hi ^ lo ^ bank_type_reg;
                            idx_next   = 9'd0;
                            phase_next = PH_WDATA;
                        end
                        else
                        begin
                            bundle.count    = 3'd5;
                            bundle.items[0] = make_rsp(1'b1, BYTE_START, ST_BUSY, sector_reg);
                            bundle.items[1] = make_rsp(1'b1, BYTE_READ, ST_BUSY, sector_reg);
                            bundle.items[2] = make_rsp(1'b1, hi, ST_BUSY, sector_reg);
                            bundle.items[3] = make_rsp(1'b1, lo, ST_BUSY, sector_reg);
                            bundle.items[4] = make_rsp(1'b1, hi ^ lo, ST_BUSY, sector_reg);
                            idx_next   = 9'd0;
                            phase_next = PH_RRESP;
                        end
                    end
                end
                CMD_DATA:
                begin
                    if (phase_reg == PH_WDATA)
                    begin
                        bundle.count    = 3'd1;
                        bundle.items[0] = make_rsp(1'b1, req_reg.data_byte, ST_BUSY,
                                                   sector_reg);
                        xor_next = xor_reg ^ req_reg.data_byte;
                        idx_next = idx_reg + 9'd1;
                        if (idx_next == SECTOR_BYTES)
                        begin
                            // The checksum byte follows the last data byte.
                            bundle.count    = 3'd2;
                            bundle.items[1] = make_rsp(1'b1, xor_next, ST_BUSY, sector_reg);
                            phase_next      = PH_WREPLY;
                        end
                    end
                end
                CMD_WRITE_REPLY:
                begin
                    if (phase_reg == PH_WREPLY)
                    begin
                        bundle.count = 3'd1;
                        phase_next   = PH_IDLE;
                        if (req_reg.rx_byte == REPLY_OK)
                        begin
                            do_advance      = 1'b1;
                            bundle.items[0] = make_rsp(1'b0, 8'h00, ST_OK, sector_reg);
                        end
                        else
                        begin
                            do_fail         = 1'b1;
                            bundle.items[0] = make_rsp(1'b0, 8'h00, fail_status, sector_reg);
                        end
                    end
                end
                CMD_READ_REPLY:
                begin
                    if (phase_reg == PH_RRESP)
                    begin
                        if (req_reg.rx_byte == REPLY_RDATA)
                        begin
                            phase_next    = PH_RDATA;
                            idx_next      = 9'd0;
                            xor_next      = 8'h00;
                            mismatch_next = 1'b0;
                            first_next    = 8'h00;
                        end
                        else
                        begin
                            do_fail         = 1'b1;
                            phase_next      = PH_IDLE;
                            bundle.count    = 3'd1;
                            bundle.items[0] = make_rsp(1'b0, 8'h00, fail_status, sector_reg);
                        end
                    end
                    else if (phase_reg == PH_RDATA)
                    begin
                        if (!idx_reg[8])
                        begin
                            if (idx_reg == 9'd0)
                            begin
                                first_next = req_reg.rx_byte;
                            end
                            xor_next = xor_reg ^ req_reg.rx_byte;
                            if (req_reg.rx_byte != req_reg.data_byte)
                            begin
                                mismatch_next = 1'b1;
                            end
                            idx_next = idx_reg + 9'd1;
                        end
                        else
                        begin
                            // Checksum byte: acknowledge with the first data byte.
                            bundle.count = 3'd1;
                            phase_next   = PH_IDLE;
                            if (req_reg.rx_byte == xor_reg && !mismatch_reg)
                            begin
                                do_advance      = 1'b1;
                                bundle.items[0] = make_rsp(1'b1, first_reg, ST_OK, sector_reg);
                            end
                            else
                            begin
                                do_fail         = 1'b1;
                                bundle.items[0] = make_rsp(1'b1, first_reg, fail_status,
                                                           sector_reg);
                            end
                        end
                    end
                end
                default:
                begin
                    bundle.count = 3'd0;
                end
            endcase
        end

        if (do_advance)
        begin
            sector_next  = adv_sector;
            handled_next = handled_reg + 12'd1;
            retries_next = 8'd0;
        end
        if (do_fail)
        begin
            retries_next = fail_retries;
        end

        done_next = (eff_image != 12'd0) && ({1'b0, handled_next} >= target);
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            bundle.items[k].all_done = done_next && (3'(k) < bundle.count);
            bundle.items[k].last     = (3'(k + 1) == bundle.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg    <= 1'b0;
            retry_limit_reg <= 8'd0;
            bank_type_reg   <= 8'd0;
            image_reg       <= 12'd0;
            split_reg       <= 1'b0;
            incr_reg        <= 1'b0;
            sector_reg      <= 11'd0;
            handled_reg     <= 12'd0;
            retries_reg     <= 8'd0;
            phase_reg       <= PH_IDLE;
            idx_reg         <= 9'd0;
            xor_reg         <= 8'd0;
            first_reg       <= 8'd0;
            mismatch_reg    <= 1'b0;
        end
        else
        begin
            req_full_reg <= req_full_next;
            sector_reg   <= sector_next;
            handled_reg  <= handled_next;
            retries_reg  <= retries_next;
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            xor_reg      <= xor_next;
            first_reg    <= first_next;
            mismatch_reg <= mismatch_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RETRY_LIMIT:  retry_limit_reg <= cfg_data[7:0];
                    CFG_BANK_TYPE:    bank_type_reg   <= cfg_data[7:0];
                    CFG_IMAGE_SECTOR: image_reg       <= cfg_data;
                    CFG_SPLIT:        split_reg       <= cfg_data[0];
                    CFG_INCREMENTAL:  incr_reg        <= cfg_data[0];
                    default:          split_reg       <= split_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
    end

endmodule

[src/stle_out_buffer.sv]
// ----------------------------------------------------------------------------
// stle_out_buffer
// Result register that holds the results of one item and hands them out in order.
// ----------------------------------------------------------------------------
module stle_out_buffer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  stle_pkg::rsp_bundle_t bundle,
    output logic                  load_ok,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output stle_pkg::rsp_item_t   rsp
);
    import stle_pkg::*;

    rsp_item_t [MAX_RESULTS-1:0] items_reg;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [2:0]                  sel_reg, sel_next;
    logic                        take;

    assign rsp_valid = (cnt_reg != 3'd0);
    assign rsp       = items_reg[sel_reg];
    assign take      = rsp_valid && !rsp_stall;
    // A new bundle may load when no result is pending or the last pending result leaves in this cycle.
    assign load_ok   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && !rsp_stall);

    always_comb
    begin
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        if (fire)
        begin
            cnt_next = bundle.count;
            sel_next = 3'd0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
            sel_next = sel_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            sel_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            items_reg <= bundle.items;
        end
    end

endmodule

[src/stle_checker.sv]
// ----------------------------------------------------------------------------
// stle_checker
// Port-level checks on the result channel of the sector transfer link engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input stle_pkg::rsp_item_t rsp
);
    import stle_pkg::*;

    // A byte that is not sent is always shown as zero.
    `ASSERT_IMPLY(a_idle_byte_zero, clk, rst_n, rsp_valid && !rsp.tx_valid, rsp.tx_byte == 8'h00)

    // Every final status closes its item on its own.
    `ASSERT_IMPLY(a_status_is_last, clk, rst_n, rsp_valid && rsp.status != ST_BUSY, rsp.last)

    // Busy results always carry a link byte.
    `ASSERT_IMPLY(a_busy_sends, clk, rst_n, rsp_valid && rsp.status == ST_BUSY, rsp.tx_valid)

    `ASSERT_NEXT(a_stall_holds, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind sector_transfer_link_engine_unit stle_checker u_stle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
